@@ rtl/first_fit_coalescing_allocator_core_assert.svh @@
// Assertion macros used by the allocator core.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFCA_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFCA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/ffca_pkg.sv @@
// Types, constants and helpers of the first-fit coalescing allocator.
package ffca_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int ALIGN_BYTES  = 8;
  localparam int PAGE_BYTES   = 4096;

  localparam int ADDR_W  = 32;
  localparam int NEED_W  = ADDR_W + 1;
  localparam int GF_W    = 16;
  localparam int PROD_W  = ADDR_W + GF_W;
  localparam int GROW_W  = PROD_W - 8;
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH   = CFG_IDX_W'(1);

  localparam logic [ADDR_W-1:0] MAX_HEAP_RST = ADDR_W'(1048576);
  localparam logic [GF_W-1:0]   GROWTH_RST   = GF_W'(256);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] free_address;
  } alloc_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;
  } alloc_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_start;
    logic [ADDR_W-1:0] seg_end;
  } seg_t;

  typedef struct packed {
    logic              fail;
    logic [ADDR_W-1:0] new_top;
  } grow_res_t;

  // Round a byte length up to the alignment unit, keeping the carry bit.
  function automatic logic [NEED_W-1:0] round_need(input logic [ADDR_W-1:0] len);
    logic [NEED_W-1:0] sum;
    sum = {1'b0, len} + NEED_W'(ALIGN_BYTES - 1);
    return sum & ~NEED_W'(ALIGN_BYTES - 1);
  endfunction

endpackage

@@ rtl/ffca_seg_tbl.sv @@
// Register file of free segments: one read port, one write port.
module ffca_seg_tbl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ffca_pkg::IDX_W-1:0]    rd_idx,
  output ffca_pkg::seg_t                rd_seg,
  input  logic                          wr_en,
  input  logic [ffca_pkg::IDX_W-1:0]    wr_idx,
  input  ffca_pkg::seg_t                wr_seg
);

  ffca_pkg::seg_t seg_r [ffca_pkg::MAX_SEGMENTS];

  // Entry 0 starts as one free page; the rest are filled before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r[0] <= '{seg_start: '0,
                    seg_end: ffca_pkg::ADDR_W'(ffca_pkg::PAGE_BYTES)};
    end else if (wr_en) begin
      seg_r[wr_idx] <= wr_seg;
    end
  end

  assign rd_seg = seg_r[rd_idx];

endmodule

@@ rtl/ffca_grow_unit.sv @@
// Heap growth: registered top times factor, then page rounding and limit check.
module ffca_grow_unit (
  input  logic                            clk,
  input  logic [ffca_pkg::ADDR_W-1:0]     heap_top,
  input  logic [ffca_pkg::GF_W-1:0]       growth_factor,
  input  logic [ffca_pkg::ADDR_W-1:0]     max_heap,
  output ffca_pkg::grow_res_t             res
);

  localparam int RND_W = ffca_pkg::GROW_W + 1;
  localparam int TOP_W = RND_W + 1;

  logic [ffca_pkg::PROD_W-1:0] prod_r;
  logic [RND_W-1:0]            grow_rnd;
  logic [TOP_W-1:0]            top_sum;

  always_ff @(posedge clk) begin
    prod_r <= heap_top * growth_factor;
  end

  always_comb begin
    grow_rnd = ({1'b0, prod_r[ffca_pkg::PROD_W-1:8]} + RND_W'(ffca_pkg::PAGE_BYTES - 1))
               & ~RND_W'(ffca_pkg::PAGE_BYTES - 1);
    top_sum  = TOP_W'(heap_top) + {1'b0, grow_rnd};
    res.fail    = (grow_rnd == '0) || (top_sum > TOP_W'(max_heap));
    res.new_top = top_sum[ffca_pkg::ADDR_W-1:0];
  end

endmodule

@@ rtl/first_fit_coalescing_allocator_core.sv @@
// Allocate: a first-fit scan, then a rebuild pass that carves the block out, then the response.
// Each growth round: multiply, check, a rebuild that extends or appends a segment, then a new scan.
// Free: a rebuild pass that merges in the freed segment, then the response; at most 32 segments.
// One item at a time: in_ready is high only while idle; the result register frees the input side.
// Cost is set by the single read port of the segment table, walked once per cycle.
// Reset (rst_n, synchronous, active low): one free page [0, 4096), heap top one page.
module first_fit_coalescing_allocator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ffca_pkg::alloc_in_t                 in_payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ffca_pkg::alloc_out_t                out_payload,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffca_pkg::ADDR_W-1:0]         cfg_data
);

`include "first_fit_coalescing_allocator_core_assert.svh"

  localparam int AW = ffca_pkg::ADDR_W;
  localparam int IW = ffca_pkg::IDX_W;
  localparam int CW = ffca_pkg::CNT_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_GROW_MUL = 8'b0000_0100,
    S_GROW_CHK = 8'b0000_1000,
    S_PASS     = 8'b0001_0000,
    S_FLUSH    = 8'b0010_0000,
    S_RESP     = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]              max_r, max_nxt;
  logic [ffca_pkg::GF_W-1:0]  gf_r, gf_nxt;
  logic [AW-1:0]              top_r, top_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              r_r, r_nxt;
  logic [CW-1:0]              w_r, w_nxt;
  logic [ffca_pkg::NEED_W-1:0] need_r, need_nxt;
  logic                       acc_v_r, acc_v_nxt;
  logic [AW-1:0]              acc_s_r, acc_s_nxt;
  logic [AW-1:0]              acc_e_r, acc_e_nxt;
  logic                       ins_pend_r, ins_pend_nxt;
  logic [AW-1:0]              ins_s_r, ins_s_nxt;
  logic [AW-1:0]              ins_e_r, ins_e_nxt;
  logic                       carve_r, carve_nxt;
  logic [IW-1:0]              k_r, k_nxt;
  logic                       ext_r, ext_nxt;
  logic [AW-1:0]              newtop_r, newtop_nxt;
  logic                       grow_pass_r, grow_pass_nxt;
  logic [AW-1:0]              res_addr_r, res_addr_nxt;
  ffca_pkg::status_t          res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ffca_pkg::alloc_out_t       out_r, out_nxt;

  logic [IW-1:0]              rd_idx;
  ffca_pkg::seg_t             rd_seg;
  logic                       tw_en;
  logic [IW-1:0]              tw_idx;
  ffca_pkg::seg_t             tw_seg;
  ffca_pkg::grow_res_t        gres;

  logic [ffca_pkg::NEED_W-1:0] in_need;
  logic [AW+1:0]              free_sum;
  logic [AW-1:0]              free_end;
  logic                       at_end;
  logic                       take_ins;
  logic [AW-1:0]              el_s, el_e;
  logic [AW-1:0]              room;
  logic [CW-1:0]              cnt_m1;

  ffca_seg_tbl u_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_seg (rd_seg),
    .wr_en  (tw_en),
    .wr_idx (tw_idx),
    .wr_seg (tw_seg)
  );

  ffca_grow_unit u_grow (
    .clk           (clk),
    .heap_top      (top_r),
    .growth_factor (gf_r),
    .max_heap      (max_r),
    .res           (gres)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    in_need  = ffca_pkg::round_need(in_payload.length);
    free_sum = {2'b00, in_payload.free_address} + {1'b0, in_need};
    free_end = (free_sum > (AW+2)'({AW{1'b1}})) ? {AW{1'b1}} : free_sum[AW-1:0];
    cnt_m1   = cnt_r - CW'(1);
    at_end   = (r_r == cnt_r);
    take_ins = ins_pend_r && (at_end || (rd_seg.seg_start >= ins_s_r));
    room     = rd_seg.seg_end - rd_seg.seg_start;
    if (take_ins) begin
      el_s = ins_s_r;
      el_e = ins_e_r;
    end else begin
      el_s = (carve_r && (r_r[IW-1:0] == k_r)) ? rd_seg.seg_start + need_r[AW-1:0]
                                                : rd_seg.seg_start;
      el_e = (ext_r && (r_r == cnt_m1)) ? newtop_r : rd_seg.seg_end;
    end
    rd_idx = (state_r == S_GROW_CHK) ? cnt_m1[IW-1:0] : r_r[IW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    max_nxt       = max_r;
    gf_nxt        = gf_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    need_nxt      = need_r;
    acc_v_nxt     = acc_v_r;
    acc_s_nxt     = acc_s_r;
    acc_e_nxt     = acc_e_r;
    ins_pend_nxt  = ins_pend_r;
    ins_s_nxt     = ins_s_r;
    ins_e_nxt     = ins_e_r;
    carve_nxt     = carve_r;
    k_nxt         = k_r;
    ext_nxt       = ext_r;
    newtop_nxt    = newtop_r;
    grow_pass_nxt = grow_pass_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    tw_en         = 1'b0;
    tw_idx        = w_r[IW-1:0];
    tw_seg        = '{seg_start: acc_s_r, seg_end: acc_e_r};

    if (cfg_valid) begin
      if (cfg_index == ffca_pkg::CFG_MAX_HEAP) begin
        max_nxt = cfg_data;
      end else if (cfg_index == ffca_pkg::CFG_GROWTH) begin
        gf_nxt = cfg_data[ffca_pkg::GF_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          need_nxt     = in_need;
          res_addr_nxt = '0;
          res_st_nxt   = ffca_pkg::ST_OK;
          r_nxt        = '0;
          w_nxt        = '0;
          acc_v_nxt    = 1'b0;
          carve_nxt    = 1'b0;
          ext_nxt      = 1'b0;
          ins_pend_nxt = 1'b0;
          if (!in_payload.kind) begin
            state_nxt = S_SCAN;
          end else if (cnt_r >= CW'(ffca_pkg::MAX_SEGMENTS)) begin
            res_st_nxt = ffca_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            ins_pend_nxt  = 1'b1;
            ins_s_nxt     = in_payload.free_address;
            ins_e_nxt     = free_end;
            grow_pass_nxt = 1'b0;
            state_nxt     = S_PASS;
          end
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_nxt = S_GROW_MUL;
        end else if ((rd_seg.seg_end > rd_seg.seg_start) && ({1'b0, room} > need_r)) begin
          res_addr_nxt  = rd_seg.seg_start;
          carve_nxt     = 1'b1;
          k_nxt         = r_r[IW-1:0];
          grow_pass_nxt = 1'b0;
          r_nxt         = '0;
          w_nxt         = '0;
          acc_v_nxt     = 1'b0;
          state_nxt     = S_PASS;
        end else begin
          r_nxt = r_r + CW'(1);
        end
      end
      S_GROW_MUL: begin
        state_nxt = S_GROW_CHK;
      end
      S_GROW_CHK: begin
        r_nxt         = '0;
        w_nxt         = '0;
        acc_v_nxt     = 1'b0;
        newtop_nxt    = gres.new_top;
        grow_pass_nxt = 1'b1;
        if (gres.fail) begin
          res_st_nxt = ffca_pkg::ST_LIMIT;
          state_nxt  = S_RESP;
        end else if ((cnt_r != '0) && (rd_seg.seg_end == top_r)) begin
          ext_nxt   = 1'b1;
          top_nxt   = gres.new_top;
          state_nxt = S_PASS;
        end else if (cnt_r >= CW'(ffca_pkg::MAX_SEGMENTS)) begin
          res_st_nxt = ffca_pkg::ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          ins_pend_nxt = 1'b1;
          ins_s_nxt    = top_r;
          ins_e_nxt    = gres.new_top;
          top_nxt      = gres.new_top;
          state_nxt    = S_PASS;
        end
      end
      S_PASS: begin
        if (at_end && !ins_pend_r) begin
          state_nxt = S_FLUSH;
        end else begin
          if (take_ins) begin
            ins_pend_nxt = 1'b0;
          end else begin
            r_nxt = r_r + CW'(1);
          end
          // Skip empty segments, merge touching ones, write back the finished one.
          if (el_s != el_e) begin
            if (!acc_v_r) begin
              acc_v_nxt = 1'b1;
              acc_s_nxt = el_s;
              acc_e_nxt = el_e;
            end else if (acc_e_r == el_s) begin
              acc_e_nxt = el_e;
            end else begin
              tw_en     = 1'b1;
              w_nxt     = w_r + CW'(1);
              acc_s_nxt = el_s;
              acc_e_nxt = el_e;
            end
          end
        end
      end
      S_FLUSH: begin
        tw_en     = acc_v_r;
        cnt_nxt   = w_r + CW'(acc_v_r);
        acc_v_nxt = 1'b0;
        carve_nxt = 1'b0;
        ext_nxt   = 1'b0;
        r_nxt     = '0;
        state_nxt = grow_pass_r ? S_SCAN : S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_nxt.address = (res_st_r == ffca_pkg::ST_OK) ? res_addr_r : '0;
          out_nxt.status  = res_st_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= ffca_pkg::MAX_HEAP_RST;
      gf_r        <= ffca_pkg::GROWTH_RST;
      top_r       <= AW'(ffca_pkg::PAGE_BYTES);
      cnt_r       <= CW'(1);
      r_r         <= '0;
      w_r         <= '0;
      acc_v_r     <= 1'b0;
      ins_pend_r  <= 1'b0;
      carve_r     <= 1'b0;
      ext_r       <= 1'b0;
      grow_pass_r <= 1'b0;
      res_st_r    <= ffca_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      gf_r        <= gf_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      r_r         <= r_nxt;
      w_r         <= w_nxt;
      acc_v_r     <= acc_v_nxt;
      ins_pend_r  <= ins_pend_nxt;
      carve_r     <= carve_nxt;
      ext_r       <= ext_nxt;
      grow_pass_r <= grow_pass_nxt;
      res_st_r    <= res_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r     <= need_nxt;
    acc_s_r    <= acc_s_nxt;
    acc_e_r    <= acc_e_nxt;
    ins_s_r    <= ins_s_nxt;
    ins_e_r    <= ins_e_nxt;
    k_r        <= k_nxt;
    newtop_r   <= newtop_nxt;
    res_addr_r <= res_addr_nxt;
    out_r      <= out_nxt;
  end

  `FFCA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(ffca_pkg::MAX_SEGMENTS), "segment count over table size")
  `FFCA_ASSERT_NOW(a_wr_behind_rd, state_r == S_PASS, w_r <= r_r + CW'(1), "write pointer passed read pointer")
  `FFCA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted item did not occupy the block")
  `FFCA_ASSERT_NEXT(a_resp_hold, state_r == S_RESP && out_valid_r && !out_ready, state_r == S_RESP, "response dropped while output stalled")

endmodule
